// ===== rtl/assert_macros.svh =====
// Assertion macros for the RTL files of the paint house block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define PHK_ASSERT(lbl, clk, rstn, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);
`define PHK_NEVER(lbl, clk, rstn, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) !(cond)) else $error(msg);
`else
`define PHK_ASSERT(lbl, clk, rstn, prop, msg)
`define PHK_NEVER(lbl, clk, rstn, cond, msg)
`endif
`endif

// ===== rtl/phk_pkg.sv =====
// Shared widths, constants and types of the paint house block.
`default_nettype none
package phk_pkg;
	localparam int COST_W  = 16;
	localparam int TOTAL_W = 32;
	localparam int NCOL_W  = 7;
	localparam int APB_W   = 32;
	localparam int PADDR_W = 3;

	localparam logic [TOTAL_W-1:0] ALL_ONES = {TOTAL_W{1'b1}};
	localparam logic [NCOL_W-1:0]  NUM_COLORS_RST = 7'd3;

	// Register indexes, taken from paddr[2].
	localparam logic REG_NUM_COLORS = 1'b0;

	typedef struct packed {
		logic [COST_W-1:0] cost;
		logic              final_house;
		logic              last;
		logic              first;
	} item_ctl_t;
endpackage
`default_nettype wire

// ===== rtl/phk_if.sv =====
// Valid/ready channel interfaces for cost words and result words.
`default_nettype none
interface phk_in_if;
	logic                      valid;
	logic                      ready;
	logic [phk_pkg::COST_W-1:0] cost;
	logic                      final_house;
	modport source(output valid, output cost, output final_house, input ready);
	modport sink(input valid, input cost, input final_house, output ready);
endinterface

interface phk_out_if;
	logic                       valid;
	logic                       ready;
	logic [phk_pkg::TOTAL_W-1:0] min_total;
	logic                       saturated;
	modport source(output valid, output min_total, output saturated, input ready);
	modport sink(input valid, input min_total, input saturated, output ready);
endinterface
`default_nettype wire

// ===== rtl/phk_front.sv =====
// Front end: accepts cost words and tags each with its color index and row position.
`default_nettype none
module phk_front #(
	parameter int MAX_COLORS = 64,
	parameter int CW = $clog2(MAX_COLORS)
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic [phk_pkg::NCOL_W-1:0] num_colors,
	phk_in_if.sink                          in,
	input  wire logic                       q_ready,
	output logic                            q_valid,
	output phk_pkg::item_ctl_t              q_ctl,
	output logic [CW-1:0]                   q_j
);
	import phk_pkg::*;

	localparam int KW = (CW + 1 > NCOL_W) ? CW + 1 : NCOL_W;

	logic [CW-1:0] color_index_q;
	logic          first_row_q;
	logic [KW-1:0] num_ext;
	logic [KW-1:0] keff;
	logic [KW-1:0] j_next;
	logic          last;
	logic          accept;

	// Out-of-range counts clamp: zero acts as one, anything above the store depth as the depth.
	always_comb begin
		num_ext = KW'(num_colors);
		if (num_ext == '0) begin
			keff = KW'(1);
		end else if (num_ext > KW'(MAX_COLORS)) begin
			keff = KW'(MAX_COLORS);
		end else begin
			keff = num_ext;
		end
	end

	assign j_next = KW'(color_index_q) + KW'(1);
	assign last   = (j_next >= keff);
	assign accept = in.valid && q_ready;

	assign in.ready          = q_ready;
	assign q_valid           = in.valid;
	assign q_j               = color_index_q;
	assign q_ctl.cost        = in.cost;
	assign q_ctl.final_house = in.final_house;
	assign q_ctl.last        = last;
	assign q_ctl.first       = first_row_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			color_index_q <= '0;
			first_row_q   <= 1'b1;
		end else if (accept) begin
			if (last) begin
				color_index_q <= '0;
				first_row_q   <= in.final_house;
			end else begin
				color_index_q <= j_next[CW-1:0];
			end
		end
	end
endmodule
`default_nettype wire

// ===== rtl/phk_queue.sv =====
// Two-entry queue that decouples the front end from the back end.
`default_nettype none
module phk_queue #(
	parameter int W = 8
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         push,
	input  wire logic [W-1:0] push_data,
	output logic              push_ready,
	input  wire logic         pop,
	output logic              pop_valid,
	output logic [W-1:0]      pop_data
);
	logic [W-1:0] entry_q [2];
	logic         wr_ptr_q;
	logic         rd_ptr_q;
	logic [1:0]   cnt_q;
	logic         do_push;
	logic         do_pop;

	assign push_ready = (cnt_q != 2'd2);
	assign pop_valid  = (cnt_q != 2'd0);
	assign pop_data   = entry_q[rd_ptr_q];
	assign do_push    = push && push_ready;
	assign do_pop     = pop && pop_valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (do_pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end
endmodule
`default_nettype wire

// ===== rtl/phk_back.sv =====
// Back end: row total store, least/second-least tracking and the result register.
`default_nettype none
`include "assert_macros.svh"
module phk_back #(
	parameter int MAX_COLORS = 64,
	parameter int CW = $clog2(MAX_COLORS)
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          q_valid,
	input  phk_pkg::item_ctl_t q_ctl,
	input  wire logic [CW-1:0] q_j,
	output logic               q_pop,
	phk_out_if.source          out
);
	import phk_pkg::*;

	logic [TOTAL_W-1:0] mem [MAX_COLORS];

	logic               vld_s1;
	item_ctl_t          ctl_s1;
	logic [CW-1:0]      j_s1;
	logic [TOTAL_W-1:0] rd_s1;
	logic               fwd_s1;
	logic [TOTAL_W-1:0] fwd_data_s1;

	logic [TOTAL_W-1:0] prev_least_q;
	logic [TOTAL_W-1:0] prev_second_q;
	logic [TOTAL_W-1:0] run_least_q;
	logic [TOTAL_W-1:0] run_second_q;

	logic               out_vld_q;
	logic [TOTAL_W-1:0] out_min_q;
	logic               out_sat_q;

	logic               out_free;
	logic               emits;
	logic               s1_go;
	logic               hit;
	logic [TOTAL_W-1:0] prev_row;
	logic [TOTAL_W-1:0] base;
	logic [TOTAL_W:0]   sum;
	logic [TOTAL_W-1:0] total;
	logic [TOTAL_W-1:0] new_least;
	logic [TOTAL_W-1:0] new_second;

	assign out_free = !out_vld_q || out.ready;
	assign emits    = ctl_s1.last && ctl_s1.final_house;
	assign s1_go    = vld_s1 && (!emits || out_free);
	assign q_pop    = q_valid && (!vld_s1 || s1_go);
	// With a single color the next word reads the entry being written this cycle.
	assign hit      = q_pop && s1_go && (q_j == j_s1);

	always_comb begin
		prev_row = fwd_s1 ? fwd_data_s1 : rd_s1;
		base     = (prev_row == prev_least_q) ? prev_second_q : prev_least_q;
		sum      = {1'b0, base} + {{(TOTAL_W + 1 - COST_W){1'b0}}, ctl_s1.cost};
		if (ctl_s1.first) begin
			total = {{(TOTAL_W - COST_W){1'b0}}, ctl_s1.cost};
		end else if (sum[TOTAL_W]) begin
			total = ALL_ONES;
		end else begin
			total = sum[TOTAL_W-1:0];
		end
		new_least  = run_least_q;
		new_second = run_second_q;
		if (total <= run_least_q) begin
			new_second = run_least_q;
			new_least  = total;
		end else if (total <= run_second_q) begin
			new_second = total;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_go) begin
			mem[j_s1] <= total;
		end
		if (q_pop) begin
			rd_s1 <= mem[q_j];
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			ctl_s1      <= q_ctl;
			j_s1        <= q_j;
			fwd_data_s1 <= total;
		end
		if (s1_go && emits) begin
			out_min_q <= new_least;
			out_sat_q <= (new_least == ALL_ONES);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1        <= 1'b0;
			fwd_s1        <= 1'b0;
			prev_least_q  <= ALL_ONES;
			prev_second_q <= ALL_ONES;
			run_least_q   <= ALL_ONES;
			run_second_q  <= ALL_ONES;
			out_vld_q     <= 1'b0;
		end else begin
			if (q_pop) begin
				vld_s1 <= 1'b1;
				fwd_s1 <= hit;
			end else if (s1_go) begin
				vld_s1 <= 1'b0;
				fwd_s1 <= 1'b0;
			end
			if (s1_go) begin
				if (ctl_s1.last) begin
					run_least_q  <= ALL_ONES;
					run_second_q <= ALL_ONES;
					if (ctl_s1.final_house) begin
						prev_least_q  <= ALL_ONES;
						prev_second_q <= ALL_ONES;
					end else begin
						prev_least_q  <= new_least;
						prev_second_q <= new_second;
					end
				end else begin
					run_least_q  <= new_least;
					run_second_q <= new_second;
				end
			end
			if (s1_go && emits) begin
				out_vld_q <= 1'b1;
			end else if (out.ready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	assign out.valid     = out_vld_q;
	assign out.min_total = out_min_q;
	assign out.saturated = out_sat_q;

	`PHK_ASSERT(a_run_order, clk, arst_n, run_least_q <= run_second_q, "run least above second")
	`PHK_ASSERT(a_prev_order, clk, arst_n, prev_least_q <= prev_second_q, "prev least above second")
	`PHK_ASSERT(a_row_clear, clk, arst_n,
		s1_go && ctl_s1.last |=> run_least_q == ALL_ONES && run_second_q == ALL_ONES,
		"running pair not cleared at row end")
	`PHK_ASSERT(a_stall_cause, clk, arst_n, vld_s1 && !s1_go |-> out_vld_q && !out.ready,
		"compute stage stalled with a free result register")
	`PHK_NEVER(a_fwd_idle, clk, arst_n, fwd_s1 && !vld_s1, "forwarded word without stage valid")
endmodule
`default_nettype wire

// ===== rtl/paint_house_k_colors_min_cost_top.sv =====
// Top level of the paint house block: register port, front end, queue and back end.
// One cost word is taken per cycle, num_colors words per house row, back to back with no
// bubble between rows or problems; the rate is set by the compute stage, which reads the
// previous row's total for the color from the row store, adds the cost to the least
// other-color total and updates the least/second-least pair (a single-color row is
// served by forwarding the total just written). The result word of a row flagged
// final_house waits in the result register while further words keep flowing, until the
// next row that ends a problem finds it still full. The num_colors register (address 0,
// reset 3, 0 acts as 1, values above MAX_COLORS clamp) must be written only while the
// block is idle, not enforced by the block. The row store needs no clearing after reset.
`default_nettype none
module paint_house_k_colors_min_cost_top #(
	parameter int MAX_COLORS = 64
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	phk_in_if.sink                           in,
	phk_out_if.source                        out,
	input  wire logic                        psel,
	input  wire logic                        penable,
	input  wire logic                        pwrite,
	input  wire logic [phk_pkg::PADDR_W-1:0] paddr,
	input  wire logic [phk_pkg::APB_W-1:0]   pwdata,
	output logic      [phk_pkg::APB_W-1:0]   prdata,
	output logic                             pready
);
	import phk_pkg::*;

	localparam int CW = $clog2(MAX_COLORS);
	localparam int QW = $bits(item_ctl_t) + CW;

	logic [NCOL_W-1:0] num_colors_q;
	logic              wr_en;

	logic              f_valid;
	item_ctl_t         f_ctl;
	logic [CW-1:0]     f_j;
	logic              q_ready;
	logic              q_valid;
	logic [QW-1:0]     q_data;
	item_ctl_t         b_ctl;
	logic [CW-1:0]     b_j;
	logic              b_pop;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_colors_q <= NUM_COLORS_RST;
		end else if (wr_en && paddr[2] == REG_NUM_COLORS) begin
			num_colors_q <= pwdata[NCOL_W-1:0];
		end
	end

	always_comb begin
		unique case (paddr[2])
			REG_NUM_COLORS: prdata = {{(APB_W - NCOL_W){1'b0}}, num_colors_q};
			default:        prdata = '0;
		endcase
	end

	phk_front #(
		.MAX_COLORS(MAX_COLORS),
		.CW(CW)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.num_colors(num_colors_q),
		.in(in),
		.q_ready(q_ready),
		.q_valid(f_valid),
		.q_ctl(f_ctl),
		.q_j(f_j)
	);

	phk_queue #(
		.W(QW)
	) u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(f_valid),
		.push_data({f_ctl, f_j}),
		.push_ready(q_ready),
		.pop(b_pop),
		.pop_valid(q_valid),
		.pop_data(q_data)
	);

	assign b_ctl = q_data[QW-1:CW];
	assign b_j   = q_data[CW-1:0];

	phk_back #(
		.MAX_COLORS(MAX_COLORS),
		.CW(CW)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.q_valid(q_valid),
		.q_ctl(b_ctl),
		.q_j(b_j),
		.q_pop(b_pop),
		.out(out)
	);
endmodule
`default_nettype wire
